/* rtl/touch_gesture_tracker_top_defines.svh */
// Assertion macros for the touch gesture tracker.
// Used by the top level; no other dependencies.
`ifndef TOUCH_GESTURE_TRACKER_TOP_DEFINES_SVH
`define TOUCH_GESTURE_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TGT_ASSERT(label, clk_s, rst_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error("assertion failed");
`define TGT_ASSERT_NEVER(label, clk_s, rst_s, cond) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
		else $error("forbidden condition");
`else
`define TGT_ASSERT(label, clk_s, rst_s, prop)
`define TGT_ASSERT_NEVER(label, clk_s, rst_s, cond)
`endif
`endif

/* rtl/tgt_pkg.sv */
// Types and constants shared by the touch gesture tracker modules.
// No dependencies.
package tgt_pkg;
	localparam int unsigned TimeW = 63;
	localparam int unsigned PosW = 16;
	localparam int unsigned PresW = 10;
	localparam int unsigned SizeW = 17;
	localparam int unsigned RadW = 33;
	localparam logic [19:0] NsPerMs = 20'd1000000;

	localparam logic [2:0] TAP_NONE = 3'd0;
	localparam logic [2:0] TAP_PEND = 3'd1;
	localparam logic [2:0] TAP_TAP = 3'd2;
	localparam logic [2:0] TAP_LONG = 3'd3;
	localparam logic [2:0] TAP_DBL = 3'd4;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_TRACK = 2'd2;

	localparam logic CFG_DBL = 1'b0;
	localparam logic CFG_LONG = 1'b1;

	typedef struct packed {
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
		logic [1:0] phase;
		logic down;
		logic [2:0] tap;
		logic [PresW-1:0] pres;
		logic [TimeW-1:0] t_press;
		logic [TimeW-1:0] t_rel;
	} entry_t;

	localparam int unsigned EntryW = $bits(entry_t);

	// Value of a never-written entry.
	function automatic entry_t entry_reset();
		entry_t e;
		e = '0;
		e.phase = PH_TRACK;
		return e;
	endfunction
endpackage

/* rtl/tgt_ram.sv */
// Generic simple dual-port synchronous RAM (separate write and read addresses) with registered read.
// No dependencies.
module tgt_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/tgt_sqrt.sv */
// Bit-serial floor square root, one result bit per cycle.
// Depends on tgt_pkg.
module tgt_sqrt import tgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [RadW-1:0] radicand,
	output logic busy,
	output logic [SizeW-1:0] root
);
	localparam int unsigned BitW = $clog2(SizeW);

	logic [RadW-1:0] rad_q;
	logic [SizeW-1:0] root_q;
	logic [BitW-1:0] bit_q;
	logic [SizeW-1:0] trial;
	logic [2*SizeW-1:0] sq;

	assign trial = root_q | (SizeW'(1) << bit_q);
	assign sq = trial * trial;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			bit_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			bit_q <= BitW'(SizeW - 1);
		end else if (busy) begin
			if (bit_q == '0) begin
				busy <= 1'b0;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			root_q <= '0;
		end else if (busy && sq <= {1'b0, rad_q}) begin
			root_q <= trial;
		end
	end
endmodule

/* rtl/touch_gesture_tracker_top.sv */
// Touch gesture tracker top level: pointer table in RAM, tap and pinch logic.
// Depends on tgt_pkg, tgt_ram, tgt_sqrt and the defines header.
//
// Channel  Direction  Handshake         Payload
// in       input      in_valid/ready    func .. time_ns
// out      output     out_valid/ready   pointer_down .. pinch_delta
// cfg      input      cfg_we            cfg_index, cfg_data
//
// Each event passes through the same steps from acceptance to its result: three table reads, one
// write-back, and the 17-step square root with its start and hand-off, run on every event.
// A new event is not taken until the previous one has left this sequence.
// Reset clears the valid bits of the pointer table and the pinch state.
// The result register lets one event be processed while a result waits; the input
// is not ready while an event is in process or waits to move into the result register.
`include "touch_gesture_tracker_top_defines.svh"
module touch_gesture_tracker_top import tgt_pkg::*; #(
	parameter int unsigned MAX_POINTERS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [2:0] pointer_index,
	input logic press_state,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic [9:0] pressure_in,
	input logic [62:0] time_ns,
	output logic out_valid,
	input logic out_ready,
	output logic pointer_down,
	output logic signed [16:0] delta_x,
	output logic signed [16:0] delta_y,
	output logic signed [10:0] delta_pressure,
	output logic [1:0] tap_kind,
	output logic pinch_active,
	output logic [16:0] pinch_size,
	output logic signed [17:0] pinch_delta
);
	localparam int unsigned AW = $clog2(MAX_POINTERS);

	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_RD1, S_ENT, S_MOD, S_SQ, S_SQW, S_OUT
	} st_t;
	st_t st_q;

	logic [15:0] dbl_q, long_q;
	logic [MAX_POINTERS-1:0] vld_q;
	logic f_q, ps_q, inr_q;
	logic [AW-1:0] idx_q;
	logic signed [15:0] x_q, y_q;
	logic [9:0] pr_q;
	logic [62:0] t_q;
	entry_t ent_q, p0_q, p1_q;
	logic [16:0] prev_q;
	logic signed [17:0] chg_q;
	logic res_down_q;
	logic signed [16:0] res_dx_q, res_dy_q;
	logic signed [10:0] res_dp_q;
	logic out_load;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata, rd;
	logic sq_start, sq_busy;
	logic [16:0] sq_root;
	logic [RadW-1:0] rad;
	logic signed [16:0] ddx, ddy;
	logic [33:0] sqx, sqy;
	logic upd_pinch;

	tgt_ram #(.Width(EntryW), .Depth(MAX_POINTERS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	tgt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(rad),
		.busy(sq_busy), .root(sq_root)
	);

	assign in_ready = (st_q == S_IDLE);
	assign out_load = (st_q == S_OUT) && (!out_valid || out_ready);

	always_comb begin
		unique case (st_q)
			S_IDLE: ram_raddr = '0;
			S_RD0: ram_raddr = AW'(1);
			default: ram_raddr = idx_q;
		endcase
	end

	// The read data is valid only when the entry was written since reset.
	always_comb begin
		logic [AW-1:0] a;
		a = (st_q == S_RD0) ? '0 : (st_q == S_RD1) ? AW'(1) : idx_q;
		rd = vld_q[a] ? ram_rdata : entry_reset();
	end

	// Pointer event update, computed from the entry read for idx_q.
	entry_t nxt;
	logic signed [16:0] dx_c, dy_c;
	logic signed [10:0] dp_c;
	logic track_c;
	always_comb begin
		logic [62:0] dt;
		logic [35:0] thr;
		nxt = ent_q;
		dx_c = '0;
		dy_c = '0;
		dp_c = '0;
		track_c = 1'b0;
		thr = '0;
		dt = '0;
		if (!f_q) begin
			nxt.pres = pr_q;
			nxt.down = ps_q;
			nxt.x = x_q;
			nxt.y = y_q;
			nxt.phase = PH_FIRST;
			if (ps_q) begin
				if (ent_q.tap == TAP_PEND || ent_q.tap == TAP_TAP) begin
					thr = dbl_q * NsPerMs;
					dt = t_q - ent_q.t_rel;
					if (t_q < ent_q.t_rel || dt < {27'd0, thr}) nxt.tap = TAP_DBL;
				end else begin
					nxt.tap = TAP_PEND;
				end
				nxt.t_press = t_q;
				nxt.t_rel = '0;
			end else begin
				if (ent_q.tap == TAP_PEND || ent_q.tap == TAP_TAP) begin
					thr = long_q * NsPerMs;
					dt = t_q - ent_q.t_press;
					nxt.t_rel = t_q;
					nxt.tap = (t_q > ent_q.t_press && dt > {27'd0, thr}) ? TAP_LONG : TAP_TAP;
				end else begin
					nxt.tap = TAP_NONE;
				end
			end
		end else begin
			nxt.x = x_q;
			nxt.y = y_q;
			if (ent_q.phase == PH_FIRST) begin
				nxt.phase = PH_SECOND;
			end else if (ent_q.phase == PH_SECOND) begin
				nxt.phase = PH_TRACK;
			end else begin
				track_c = 1'b1;
				dx_c = 17'(x_q) - 17'(ent_q.x);
				dy_c = 17'(y_q) - 17'(ent_q.y);
				nxt.tap = TAP_NONE;
			end
			dp_c = 11'({1'b0, pr_q}) - 11'({1'b0, ent_q.pres});
			nxt.pres = pr_q;
		end
	end

	assign ddx = 17'(p1_q.x) - 17'(p0_q.x);
	assign ddy = 17'(p1_q.y) - 17'(p0_q.y);
	assign sqx = 34'(ddx * ddx);
	assign sqy = 34'(ddy * ddy);
	assign rad = RadW'(sqx + sqy);

	always_comb begin
		ram_we = (st_q == S_MOD) && inr_q;
		ram_waddr = idx_q;
		ram_wdata = nxt;
	end

	logic pa_c;
	assign pa_c = p0_q.down && p1_q.down;
	assign upd_pinch = inr_q && f_q && track_c;
	assign sq_start = (st_q == S_SQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			dbl_q <= 16'd250;
			long_q <= 16'd500;
			vld_q <= '0;
			prev_q <= '0;
			chg_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DBL: dbl_q <= cfg_data;
					CFG_LONG: long_q <= cfg_data;
				endcase
			end
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid && in_ready) st_q <= S_RD0;
				S_RD0: st_q <= S_RD1;
				S_RD1: st_q <= S_ENT;
				S_ENT: st_q <= S_MOD;
				S_MOD: begin
					if (inr_q) vld_q[idx_q] <= 1'b1;
					if (inr_q && !f_q) begin
						prev_q <= '0;
						chg_q <= '0;
					end
					st_q <= S_SQ;
				end
				S_SQ: st_q <= S_SQW;
				S_SQW: begin
					if (!sq_busy) begin
						if (upd_pinch) begin
							if (pa_c) begin
								chg_q <= 18'(sq_root) - 18'(prev_q);
								prev_q <= sq_root;
							end else begin
								prev_q <= '0;
								chg_q <= '0;
							end
						end
						st_q <= S_OUT;
					end
				end
				S_OUT: if (out_load) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE) begin
			f_q <= func;
			ps_q <= press_state;
			idx_q <= AW'(pointer_index);
			inr_q <= (32'(pointer_index) < MAX_POINTERS);
			x_q <= pos_x;
			y_q <= pos_y;
			pr_q <= pressure_in;
			t_q <= time_ns;
		end
		if (st_q == S_RD0) p0_q <= rd;
		if (st_q == S_RD1) p1_q <= rd;
		if (st_q == S_ENT) ent_q <= rd;
		if (st_q == S_MOD) begin
			if (inr_q && idx_q == '0) p0_q <= nxt;
			if (inr_q && idx_q == AW'(1)) p1_q <= nxt;
			res_down_q <= inr_q && nxt.down;
			res_dx_q <= inr_q ? dx_c : '0;
			res_dy_q <= inr_q ? dy_c : '0;
			res_dp_q <= inr_q ? dp_c : '0;
		end
		if (out_load) begin
			pointer_down <= res_down_q;
			delta_x <= res_dx_q;
			delta_y <= res_dy_q;
			delta_pressure <= res_dp_q;
			pinch_active <= pa_c;
			pinch_size <= pa_c ? sq_root : '0;
			pinch_delta <= chg_q;
			if (pa_c) tap_kind <= 2'd0;
			else begin
				unique case (p0_q.tap)
					TAP_TAP: tap_kind <= 2'd1;
					TAP_LONG: tap_kind <= 2'd2;
					TAP_DBL: tap_kind <= 2'd3;
					default: tap_kind <= 2'd0;
				endcase
			end
		end
	end

	`TGT_ASSERT(a_no_accept_busy, clk, arst_n, (st_q != S_IDLE) |-> !in_ready)
	`TGT_ASSERT(a_out_after_seq, clk, arst_n, $rose(out_valid) |-> $past(st_q) == S_OUT)
	`TGT_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid && $stable(pinch_size))
	`TGT_ASSERT_NEVER(a_sqrt_idle_out, clk, arst_n, st_q == S_OUT && sq_busy)
endmodule

/* bench/tb_touch_gesture_tracker_top.sv */
// Self-checking bench for the touch gesture tracker: random and directed touch events.
// A scoreboard class predicts each result from its own pointer table and checks it.
// Depends on tgt_pkg and the touch_gesture_tracker_top RTL.
module tb_touch_gesture_tracker_top import tgt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic func;
		logic [2:0] ptr;
		logic st;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [9:0] pr;
		logic [62:0] t;
	} touch_ev_t;

	typedef struct {
		logic down;
		logic [16:0] dx;
		logic [16:0] dy;
		logic [10:0] dp;
		logic [1:0] kind;
		logic pa;
		logic [16:0] psize;
		logic [17:0] pdelta;
	} gesture_res_t;

	class gesture_scoreboard;
		logic [15:0] dbl_ms, long_ms;
		logic signed [15:0] px[8], py[8];
		logic [1:0] phase[8];
		logic down[8];
		logic [2:0] tap[8];
		logic [9:0] lpr[8];
		logic [62:0] tpress[8], trel[8];
		longint prev_pinch, pinch_chg;
		gesture_res_t pending[$];
		int errors;

		function new();
			dbl_ms = 250;
			long_ms = 500;
			for (int i = 0; i < 8; i++) begin
				px[i] = 0; py[i] = 0; phase[i] = PH_TRACK; down[i] = 0;
				tap[i] = TAP_NONE; lpr[i] = 0; tpress[i] = 0; trel[i] = 0;
			end
			prev_pinch = 0;
			pinch_chg = 0;
			errors = 0;
		endfunction

		function longint isqrt(longint v);
			longint r, c;
			r = 0;
			for (int b = 17; b >= 0; b--) begin
				c = r | (longint'(1) << b);
				if (c * c <= v) r = c;
			end
			return r;
		endfunction

		function longint distance();
			longint ddx, ddy;
			ddx = longint'(px[1]) - longint'(px[0]);
			ddy = longint'(py[1]) - longint'(py[0]);
			return isqrt(ddx * ddx + ddy * ddy);
		endfunction

		function void note_event(touch_ev_t e);
			gesture_res_t r;
			longint ddx, ddy, ddp, s;
			logic [63:0] thr, tt;
			int i;
			i = e.ptr;
			ddx = 0; ddy = 0; ddp = 0;
			tt = {1'b0, e.t};
			if (!e.func) begin
				lpr[i] = e.pr; down[i] = e.st; px[i] = e.x; py[i] = e.y;
				phase[i] = PH_FIRST; prev_pinch = 0; pinch_chg = 0;
				if (e.st) begin
					if (tap[i] == TAP_PEND || tap[i] == TAP_TAP) begin
						thr = 64'(dbl_ms) * 64'd1000000;
						if (tt < {1'b0, trel[i]} || (tt - {1'b0, trel[i]}) < thr)
							tap[i] = TAP_DBL;
					end else
						tap[i] = TAP_PEND;
					tpress[i] = e.t;
					trel[i] = '0;
				end else if (tap[i] == TAP_PEND || tap[i] == TAP_TAP) begin
					thr = 64'(long_ms) * 64'd1000000;
					trel[i] = e.t;
					tap[i] = (tt > {1'b0, tpress[i]} && (tt - {1'b0, tpress[i]}) > thr)
						? TAP_LONG : TAP_TAP;
				end else
					tap[i] = TAP_NONE;
			end else begin
				if (phase[i] == PH_FIRST) begin
					px[i] = e.x; py[i] = e.y; phase[i] = PH_SECOND;
				end else if (phase[i] == PH_SECOND) begin
					px[i] = e.x; py[i] = e.y; phase[i] = PH_TRACK;
				end else begin
					ddx = longint'(e.x) - longint'(px[i]);
					ddy = longint'(e.y) - longint'(py[i]);
					px[i] = e.x; py[i] = e.y; tap[i] = TAP_NONE;
					if (down[0] && down[1]) begin
						s = distance();
						pinch_chg = s - prev_pinch;
						prev_pinch = s;
					end else begin
						prev_pinch = 0; pinch_chg = 0;
					end
				end
				ddp = longint'(e.pr) - longint'(lpr[i]);
				lpr[i] = e.pr;
			end
			r.down = down[i];
			r.dx = ddx[16:0]; r.dy = ddy[16:0]; r.dp = ddp[10:0];
			r.pa = down[0] && down[1];
			r.psize = r.pa ? 17'(distance()) : '0;
			r.kind = 2'd0;
			if (!r.pa)
				case (tap[0])
					TAP_TAP: r.kind = 2'd1;
					TAP_LONG: r.kind = 2'd2;
					TAP_DBL: r.kind = 2'd3;
					default: r.kind = 2'd0;
				endcase
			r.pdelta = pinch_chg[17:0];
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(gesture_res_t a);
			gesture_res_t x;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.down !== x.down) begin
				$error("pointer_down exp %0h got %0h", x.down, a.down); errors++;
			end
			if (a.dx !== x.dx) begin
				$error("delta_x exp %0h got %0h", x.dx, a.dx); errors++;
			end
			if (a.dy !== x.dy) begin
				$error("delta_y exp %0h got %0h", x.dy, a.dy); errors++;
			end
			if (a.dp !== x.dp) begin
				$error("delta_pressure exp %0h got %0h", x.dp, a.dp); errors++;
			end
			if (a.kind !== x.kind) begin
				$error("tap_kind exp %0h got %0h", x.kind, a.kind); errors++;
			end
			if (a.pa !== x.pa) begin
				$error("pinch_active exp %0h got %0h", x.pa, a.pa); errors++;
			end
			if (a.psize !== x.psize) begin
				$error("pinch_size exp %0h got %0h", x.psize, a.psize); errors++;
			end
			if (a.pdelta !== x.pdelta) begin
				$error("pinch_delta exp %0h got %0h", x.pdelta, a.pdelta); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready, func, press_state;
	logic [2:0] pointer_index;
	logic signed [15:0] pos_x, pos_y;
	logic [9:0] pressure_in;
	logic [62:0] time_ns;
	logic out_valid, out_ready, pointer_down, pinch_active;
	logic signed [16:0] delta_x, delta_y;
	logic signed [10:0] delta_pressure;
	logic [1:0] tap_kind;
	logic [16:0] pinch_size;
	logic signed [17:0] pinch_delta;

	gesture_scoreboard sb;
	logic [62:0] clock_ns;
	bit hold_off;
	bit stall_mode;

	touch_gesture_tracker_top dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: stall pattern with switchable density, plus one long hold-off.
	initial begin
		int hold;
		out_ready = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				gesture_res_t r;
				r.down = pointer_down; r.dx = delta_x; r.dy = delta_y;
				r.dp = delta_pressure; r.kind = tap_kind; r.pa = pinch_active;
				r.psize = pinch_size; r.pdelta = pinch_delta;
				sb.check_result(r);
			end
			@(negedge clk);
			if (hold_off && hold == 0) hold = 300;
			if (hold > 0) begin
				hold--;
				if (hold == 0) hold_off = 0;
				out_ready <= 0;
			end else if (stall_mode)
				out_ready <= ($urandom_range(0, 3) != 0);
			else
				out_ready <= 1;
		end
	end

	task automatic send_event(touch_ev_t e);
		func <= e.func; pointer_index <= e.ptr; press_state <= e.st;
		pos_x <= e.x; pos_y <= e.y; pressure_in <= e.pr; time_ns <= e.t;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_event(e);
		@(negedge clk);
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic make_event(bit f, int p, bit s, int xx, int yy, output touch_ev_t e);
		e.func = f; e.ptr = 3'(p); e.st = s; e.x = 16'(xx); e.y = 16'(yy);
		e.pr = 10'($urandom_range(0, 1023));
		clock_ns += 63'($urandom_range(0, 600)) * 63'd1000000
			+ 63'($urandom_range(0, 999999));
		e.t = clock_ns;
		if ($urandom_range(0, 40) == 0) e.t = 63'({$urandom, $urandom});
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_reg(logic idx, logic [15:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_DBL) sb.dbl_ms = v; else sb.long_ms = v;
		@(negedge clk);
	endtask

	task automatic gap();
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	task automatic rand_event(output touch_ev_t e);
		int p, k;
		p = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1) : $urandom_range(0, 7);
		k = $urandom_range(0, 9);
		make_event(k >= 4, p, $urandom_range(0, 1),
			($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400) - 200,
			($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400) - 200, e);
	endtask

	task automatic tap_sequence(int p);
		touch_ev_t e;
		make_event(0, p, 1, $urandom_range(0, 100), $urandom_range(0, 100), e);
		send_event(e);
		if ($urandom_range(0, 2) == 0) begin
			make_event(1, p, 0, $urandom, $urandom, e);
			send_event(e);
		end
		make_event(0, p, 0, $urandom_range(0, 100), $urandom_range(0, 100), e);
		send_event(e);
		make_event(0, p, 1, $urandom_range(0, 100), $urandom_range(0, 100), e);
		send_event(e);
	endtask

	initial begin
		touch_ev_t e;
		logic [15:0] cfgs[4][2];
		int cnt;
		bit held, paused;
		sb = new();
		clock_ns = 0;
		hold_off = 0;
		stall_mode = 0;
		held = 0;
		paused = 0;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
		func = 0; pointer_index = 0; press_state = 0; pos_x = 0; pos_y = 0;
		pressure_in = 0; time_ns = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, pinch, taps, backwards time, out-of-range deltas.
		make_event(1, 0, 0, 32767, -32768, e); e.pr = 10'd1023; send_event(e);
		make_event(1, 0, 0, -32768, 32767, e); e.pr = 10'd0; send_event(e);
		make_event(0, 0, 1, -32768, -32768, e); send_event(e);
		make_event(0, 1, 1, 32767, 32767, e); send_event(e);
		for (int k = 0; k < 3; k++) begin
			make_event(1, 1, 0, 32767 - k, 32767, e); send_event(e);
		end
		make_event(1, 0, 0, 0, 0, e); send_event(e);
		make_event(0, 1, 0, 5, 5, e); send_event(e);
		make_event(0, 0, 0, 0, 0, e); e.t = 63'd0; send_event(e);
		make_event(0, 0, 1, 0, 0, e); e.t = 63'h7fffffffffffffff; send_event(e);
		make_event(0, 0, 0, 0, 0, e); e.t = 63'd1; send_event(e);
		make_event(0, 0, 1, 0, 0, e); e.t = 63'd0; send_event(e);
		make_event(0, 7, 1, 1, 1, e); send_event(e);
		make_event(0, 7, 0, 1, 1, e); send_event(e);
		tap_sequence(0);
		drain();

		cfgs = '{'{16'd0, 16'd0}, '{16'hffff, 16'hffff}, '{16'd1, 16'd2},
			'{16'd250, 16'd500}};
		for (int ph = 0; ph < 4; ph++) begin
			set_reg(CFG_DBL, cfgs[ph][0]);
			set_reg(CFG_LONG, cfgs[ph][1]);
			stall_mode = (ph % 2 == 1);
			cnt = 0;
			while (cnt < 410) begin
				if (ph == 1 && cnt >= 100 && !held) begin
					hold_off = 1;
					held = 1;
				end
				if (ph == 2 && cnt >= 200 && !paused) begin
					drain();
					paused = 1;
				end
				if ($urandom_range(0, 2) == 0) begin
					tap_sequence($urandom_range(0, 2));
					cnt += 3;
				end else begin
					rand_event(e);
					send_event(e);
					cnt++;
				end
				gap();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/tgt_pkg.sv
rtl/tgt_ram.sv
rtl/tgt_sqrt.sv
rtl/touch_gesture_tracker_top.sv
bench/tb_touch_gesture_tracker_top.sv
